// ----- design/plane_reflection_core_assert.svh -----
// Assertion macros used by the checker of the reflection core.
`ifndef PLANE_REFLECTION_CORE_ASSERT_SVH
`define PLANE_REFLECTION_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("plane reflection core check failed");

// The consequent must hold in the cycle after the antecedent.
`define PRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("plane reflection core check failed");

`endif

// ----- design/prefl_pkg.sv -----
package prefl_pkg;

  localparam int CW     = 24;
  localparam int EW     = 25;
  localparam int NW     = 50;
  localparam int HW     = 25;
  localparam int NSQW   = 100;
  localparam int VNW    = 73;
  localparam int SW     = 75;
  localparam int SMW    = 74;
  localparam int PRW    = 124;
  localparam int NUMW   = 128;
  localparam int QW     = 27;
  localparam int RW     = 29;
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [2:0][CW-1:0] v;
    logic [2:0]         nneg;
    logic [2:0][NW-1:0] nmag;
  } fq_t;

  typedef struct packed {
    logic [2:0][CW-1:0] v;
    logic [2:0]         nneg;
    logic               sneg;
    logic               degen;
  } side_t;

endpackage

// ----- design/prefl_front.sv -----
module prefl_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  logic [2:0][prefl_pkg::CW-1:0]          vec_i,
  input  logic [2:0][prefl_pkg::CW-1:0]          pa_i,
  input  logic [2:0][prefl_pkg::CW-1:0]          pb_i,
  input  logic [2:0][prefl_pkg::CW-1:0]          pc_i,
  output logic                                   valid_o,
  output prefl_pkg::fq_t                         data_o
);

  localparam int CW = prefl_pkg::CW;
  localparam int EW = prefl_pkg::EW;
  localparam int NW = prefl_pkg::NW;

  logic                 v1_q, v2_q;
  logic [2:0][CW-1:0]   vec1_q;
  logic [2:0][EW-1:0]   e_q, f_q;
  logic signed [2*EW-1:0] p_l [3];
  logic signed [2*EW-1:0] p_r [3];
  logic [2*EW:0]        n_w [3];
  logic [2*EW:0]        n_neg_w [3];
  prefl_pkg::fq_t       data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec1_q <= vec_i;
      for (int i = 0; i < 3; i++) begin
        e_q[i] <= {pb_i[i][CW-1], pb_i[i]} - {pa_i[i][CW-1], pa_i[i]};
        f_q[i] <= {pc_i[i][CW-1], pc_i[i]} - {pa_i[i][CW-1], pa_i[i]};
      end
    end
  end

  always_comb begin
    p_l[0] = $signed(e_q[1]) * $signed(f_q[2]);
    p_r[0] = $signed(e_q[2]) * $signed(f_q[1]);
    p_l[1] = $signed(e_q[2]) * $signed(f_q[0]);
    p_r[1] = $signed(e_q[0]) * $signed(f_q[2]);
    p_l[2] = $signed(e_q[0]) * $signed(f_q[1]);
    p_r[2] = $signed(e_q[1]) * $signed(f_q[0]);
    for (int i = 0; i < 3; i++) begin
      n_w[i]     = {p_l[i][2*EW-1], p_l[i]} - {p_r[i][2*EW-1], p_r[i]};
      n_neg_w[i] = -n_w[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q.v <= vec1_q;
      for (int i = 0; i < 3; i++) begin
        data_q.nneg[i] <= n_w[i][2*EW];
        data_q.nmag[i] <= n_w[i][2*EW] ? n_neg_w[i][NW-1:0] : n_w[i][NW-1:0];
      end
    end
  end

  assign valid_o = v2_q;
  assign data_o  = data_q;

endmodule

// ----- design/prefl_queue.sv -----
module prefl_queue #(
  parameter int Depth = prefl_pkg::QDEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  prefl_pkg::fq_t data_i,
  input  logic           rd_i,
  output prefl_pkg::fq_t data_o,
  output logic           valid_o,
  output logic           full_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  prefl_pkg::fq_t  mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) begin
        wp_q <= (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      end
      if (rd_i) begin
        rp_q <= (rp_q == PtrW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(wr_i) - CntW'(rd_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rp_q];
  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntW'(Depth));

endmodule

// ----- design/prefl_div.sv -----
module prefl_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  prefl_pkg::side_t                    side_i,
  input  logic [2:0][prefl_pkg::NUMW-1:0]     num_i,
  input  logic [prefl_pkg::NUMW-1:0]          den_i,
  output logic                                valid_o,
  output prefl_pkg::side_t                    side_o,
  output logic [2:0][prefl_pkg::QW-1:0]       quo_o
);

  localparam int NUMW = prefl_pkg::NUMW;
  localparam int QW   = prefl_pkg::QW;

  logic [QW-1:0]            vld_q;
  logic [2:0][NUMW-1:0]     rem_in [QW];
  logic [2:0][NUMW-1:0]     rem_q  [QW];
  logic [2:0][QW-1:0]       quo_in [QW];
  logic [2:0][QW-1:0]       quo_q  [QW];
  logic [NUMW-1:0]          den_in [QW];
  logic [NUMW-1:0]          den_q  [QW];
  prefl_pkg::side_t         side_in [QW];
  prefl_pkg::side_t         side_q  [QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int Sh = QW - 1 - k;
    logic [NUMW-1:0]      dsh;
    logic [2:0]           ge;
    logic [2:0][NUMW-1:0] rem_d;

    if (k == 0) begin : g_first
      assign rem_in[k]  = num_i;
      assign quo_in[k]  = '0;
      assign den_in[k]  = den_i;
      assign side_in[k] = side_i;
    end else begin : g_next
      assign rem_in[k]  = rem_q[k-1];
      assign quo_in[k]  = quo_q[k-1];
      assign den_in[k]  = den_q[k-1];
      assign side_in[k] = side_q[k-1];
    end

    always_comb begin
      dsh = den_in[k] << Sh;
      for (int c = 0; c < 3; c++) begin
        ge[c]    = (rem_in[k][c] >= dsh);
        rem_d[c] = ge[c] ? rem_in[k][c] - dsh : rem_in[k][c];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        den_q[k]  <= den_in[k];
        side_q[k] <= side_in[k];
        for (int c = 0; c < 3; c++) begin
          quo_q[k][c] <= {quo_in[k][c][QW-2:0], ge[c]};
        end
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign side_o  = side_q[QW-1];
  assign quo_o   = quo_q[QW-1];

endmodule

// ----- design/prefl_back.sv -----
module prefl_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  prefl_pkg::fq_t                    data_i,
  output logic                              rd_o,
  input  logic                              stall_i,
  output logic                              valid_o,
  output logic [2:0][prefl_pkg::CW-1:0]     refl_o,
  output logic                              degen_o
);

  localparam int CW   = prefl_pkg::CW;
  localparam int NW   = prefl_pkg::NW;
  localparam int HW   = prefl_pkg::HW;
  localparam int NSQW = prefl_pkg::NSQW;
  localparam int VNW  = prefl_pkg::VNW;
  localparam int SW   = prefl_pkg::SW;
  localparam int SMW  = prefl_pkg::SMW;
  localparam int PRW  = prefl_pkg::PRW;
  localparam int NUMW = prefl_pkg::NUMW;
  localparam int QW   = prefl_pkg::QW;
  localparam int RW   = prefl_pkg::RW;

  logic                 en;
  logic [6:0]           vld_q;
  prefl_pkg::side_t     side_q [7];
  logic [2:0][NW-1:0]   nm_q [4];

  logic [2:0][CW-1:0]   vm;
  logic [2:0][2*HW-1:0] phh_q, phl_q, pll_q;
  logic [2:0][CW+HW-1:0] qh_q, ql_q;
  logic [2:0][NSQW-1:0] nsq_q;
  logic [2:0][VNW-1:0]  vn_q;
  logic [2:0]           vnn_q;
  logic [NSQW-1:0]      dd_q, dd4_q, dd5_q, dd6_q;
  logic [SW-1:0]        s_q, s_neg;
  logic [SW-1:0]        s_term [3];
  logic [SMW-1:0]       sm_q;
  logic [2:0][5:0][2*HW-1:0] pp_q;
  logic [2:0][PRW-1:0]  pr_q;
  logic [2:0][NUMW-1:0] num_q;
  logic [NUMW-1:0]      den_q;

  logic                 dv_valid;
  prefl_pkg::side_t     dv_side;
  logic [2:0][QW-1:0]   dv_quo;

  logic [RW-1:0]        t_w [3];
  logic [RW-1:0]        t_s [3];
  logic [RW-1:0]        r_w [3];
  logic [2:0][CW-1:0]   r_sat;

  logic                 vo_q;
  logic [2:0][CW-1:0]   refl_q;
  logic                 degen_q;

  assign en   = !(vo_q && stall_i);
  assign rd_o = valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      vo_q  <= 1'b0;
    end else if (en) begin
      vld_q <= {vld_q[5:0], valid_i};
      vo_q  <= dv_valid;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vm[i] = data_i.v[i][CW-1] ? (~data_i.v[i] + 1'b1) : data_i.v[i];
    end
    for (int i = 0; i < 3; i++) begin
      s_term[i] = vnn_q[i] ? (~SW'(vn_q[i]) + 1'b1) : SW'(vn_q[i]);
    end
    s_neg = ~s_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{v: data_i.v, nneg: data_i.nneg, sneg: 1'b0, degen: 1'b0};
      nm_q[0]   <= data_i.nmag;
      for (int i = 0; i < 3; i++) begin
        phh_q[i] <= data_i.nmag[i][NW-1:HW] * data_i.nmag[i][NW-1:HW];
        phl_q[i] <= data_i.nmag[i][NW-1:HW] * data_i.nmag[i][HW-1:0];
        pll_q[i] <= data_i.nmag[i][HW-1:0] * data_i.nmag[i][HW-1:0];
        qh_q[i]  <= vm[i] * data_i.nmag[i][NW-1:HW];
        ql_q[i]  <= vm[i] * data_i.nmag[i][HW-1:0];
      end

      side_q[1] <= side_q[0];
      nm_q[1]   <= nm_q[0];
      for (int i = 0; i < 3; i++) begin
        nsq_q[i] <= (NSQW'(phh_q[i]) << (2 * HW)) + (NSQW'(phl_q[i]) << (HW + 1))
                    + NSQW'(pll_q[i]);
        vn_q[i]  <= (VNW'(qh_q[i]) << HW) + VNW'(ql_q[i]);
        vnn_q[i] <= side_q[0].v[i][CW-1] ^ side_q[0].nneg[i];
      end

      side_q[2] <= side_q[1];
      nm_q[2]   <= nm_q[1];
      dd_q      <= nsq_q[0] + nsq_q[1] + nsq_q[2];
      s_q       <= s_term[0] + s_term[1] + s_term[2];

      side_q[3] <= '{v: side_q[2].v, nneg: side_q[2].nneg, sneg: s_q[SW-1],
                     degen: (dd_q == '0)};
      nm_q[3]   <= nm_q[2];
      dd4_q     <= dd_q;
      sm_q      <= s_q[SW-1] ? s_neg[SMW-1:0] : s_q[SMW-1:0];

      side_q[4] <= side_q[3];
      dd5_q     <= dd4_q;
      for (int i = 0; i < 3; i++) begin
        pp_q[i][0] <= nm_q[3][i][HW-1:0]  * sm_q[HW-1:0];
        pp_q[i][1] <= nm_q[3][i][NW-1:HW] * sm_q[HW-1:0];
        pp_q[i][2] <= nm_q[3][i][HW-1:0]  * sm_q[2*HW-1:HW];
        pp_q[i][3] <= nm_q[3][i][NW-1:HW] * sm_q[2*HW-1:HW];
        pp_q[i][4] <= nm_q[3][i][HW-1:0]  * sm_q[SMW-1:2*HW];
        pp_q[i][5] <= nm_q[3][i][NW-1:HW] * sm_q[SMW-1:2*HW];
      end

      side_q[5] <= side_q[4];
      dd6_q     <= dd5_q;
      for (int i = 0; i < 3; i++) begin
        pr_q[i] <= PRW'(pp_q[i][0])
                   + ((PRW'(pp_q[i][1]) + PRW'(pp_q[i][2])) << HW)
                   + ((PRW'(pp_q[i][3]) + PRW'(pp_q[i][4])) << (2 * HW))
                   + (PRW'(pp_q[i][5]) << (3 * HW));
      end

      side_q[6] <= side_q[5];
      den_q     <= NUMW'(dd6_q) << 1;
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= (NUMW'(pr_q[i]) << 2) + NUMW'(dd6_q);
      end
    end
  end

  prefl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld_q[6]),
    .side_i  (side_q[6]),
    .num_i   (num_q),
    .den_i   (den_q),
    .valid_o (dv_valid),
    .side_o  (dv_side),
    .quo_o   (dv_quo)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_w[i] = RW'(dv_quo[i]);
      t_s[i] = (dv_side.sneg ^ dv_side.nneg[i]) ? (~t_w[i] + 1'b1) : t_w[i];
      r_w[i] = {{(RW - CW){dv_side.v[i][CW-1]}}, dv_side.v[i]} - t_s[i];
      if (r_w[i][RW-1:CW-1] == '0 || r_w[i][RW-1:CW-1] == '1) begin
        r_sat[i] = r_w[i][CW-1:0];
      end else begin
        r_sat[i] = {r_w[i][RW-1], {(CW - 1){~r_w[i][RW-1]}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      degen_q <= dv_side.degen;
      refl_q  <= dv_side.degen ? dv_side.v : r_sat;
    end
  end

  assign valid_o = vo_q;
  assign refl_o  = refl_q;
  assign degen_o = degen_q;

endmodule

// ----- design/plane_reflection_core.sv -----
// Channel   Direction  Handshake           Payload
// request   in         valid_i / stall_o   vec_*_i, point_a_*_i, point_b_*_i, point_c_*_i
// result    out        valid_o / stall_i   refl_*_o, degenerate_o
//
// One request is taken every cycle while stall_o is low.
// A request's result passes through the front stages, the queue, the product
// stages and one divider stage per quotient bit before the output register.
// Reset clears all valid flags and the queue; no results are pending after it.
// A stalled result freezes the back pipeline; the queue then fills and stall_o rises.
module plane_reflection_core #(
  parameter int QueueDepth = prefl_pkg::QDEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic signed [23:0] vec_x_i,
  input  logic signed [23:0] vec_y_i,
  input  logic signed [23:0] vec_z_i,
  input  logic signed [23:0] point_a_x_i,
  input  logic signed [23:0] point_a_y_i,
  input  logic signed [23:0] point_a_z_i,
  input  logic signed [23:0] point_b_x_i,
  input  logic signed [23:0] point_b_y_i,
  input  logic signed [23:0] point_b_z_i,
  input  logic signed [23:0] point_c_x_i,
  input  logic signed [23:0] point_c_y_i,
  input  logic signed [23:0] point_c_z_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic signed [23:0] refl_x_o,
  output logic signed [23:0] refl_y_o,
  output logic signed [23:0] refl_z_o,
  output logic        degenerate_o
);

  logic [2:0][prefl_pkg::CW-1:0] vec, pa, pb, pc, refl;
  logic                          f_valid, q_full, q_valid, q_rd;
  prefl_pkg::fq_t                f_data, q_data;

  assign vec = {vec_z_i, vec_y_i, vec_x_i};
  assign pa  = {point_a_z_i, point_a_y_i, point_a_x_i};
  assign pb  = {point_b_z_i, point_b_y_i, point_b_x_i};
  assign pc  = {point_c_z_i, point_c_y_i, point_c_x_i};

  assign stall_o = q_full;

  prefl_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (!q_full),
    .valid_i (valid_i),
    .vec_i   (vec),
    .pa_i    (pa),
    .pb_i    (pb),
    .pc_i    (pc),
    .valid_o (f_valid),
    .data_o  (f_data)
  );

  prefl_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (f_valid && !q_full),
    .data_i  (f_data),
    .rd_i    (q_rd),
    .data_o  (q_data),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  prefl_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .data_i  (q_data),
    .rd_o    (q_rd),
    .stall_i (stall_i),
    .valid_o (valid_o),
    .refl_o  (refl),
    .degen_o (degenerate_o)
  );

  assign refl_x_o = refl[0];
  assign refl_y_o = refl[1];
  assign refl_z_o = refl[2];

endmodule

// ----- design/prefl_checker.sv -----
`include "plane_reflection_core_assert.svh"

module prefl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_o,
  input logic        stall_i,
  input logic        stall_o,
  input logic [23:0] refl_x_o,
  input logic [23:0] refl_y_o,
  input logic [23:0] refl_z_o,
  input logic        degenerate_o
);

  `PRC_ASSERT_NEXT(a_out_hold, valid_o && stall_i, valid_o)
  `PRC_ASSERT_NEXT(a_out_stable, valid_o && stall_i, $stable(refl_x_o) && $stable(refl_y_o) && $stable(refl_z_o) && $stable(degenerate_o))
  `PRC_ASSERT_NEXT(a_drain_frees, !(valid_o && stall_i), !stall_o)
  `PRC_ASSERT_NOW(a_free_cause, $fell(stall_o), $past(!(valid_o && stall_i)))

endmodule

bind plane_reflection_core prefl_checker u_prefl_checker (.*);

// ----- bench/plane_reflection_core_tb.sv -----
module plane_reflection_core_tb;

  localparam int HALF_PERIOD = 5;
  localparam int NUM_RANDOM = 1500;
  localparam int DRAIN_CYCLES = 60;
  localparam longint QMAX = 8388607;
  localparam longint QMIN = -8388608;

  typedef struct {
    logic [23:0] v[3];
    logic [23:0] a[3];
    logic [23:0] b[3];
    logic [23:0] c[3];
  } request_t;

  typedef struct {
    logic [23:0] r[3];
    logic        degen;
  } reflection_t;

  class reflection_scoreboard;
    reflection_t pending[$];
    int errors;
    int checked;
    int degenerate_seen;

    function automatic reflection_t reflect(request_t q);
      reflection_t res;
      longint v[3], e[3], f[3], n[3];
      logic signed [255:0] dd, s, sm, nm, num, tm, t, r, vw, nw;
      logic sneg;
      dd = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        v[i] = longint'($signed(q.v[i]));
        e[i] = longint'($signed(q.b[i])) - longint'($signed(q.a[i]));
        f[i] = longint'($signed(q.c[i])) - longint'($signed(q.a[i]));
      end
      n[0] = e[1] * f[2] - e[2] * f[1];
      n[1] = e[2] * f[0] - e[0] * f[2];
      n[2] = e[0] * f[1] - e[1] * f[0];
      for (int i = 0; i < 3; i++) begin
        nw = n[i];
        vw = v[i];
        dd = dd + nw * nw;
        s = s + vw * nw;
      end
      res.degen = (dd == 0);
      if (res.degen) begin
        for (int i = 0; i < 3; i++) res.r[i] = q.v[i];
        return res;
      end
      sneg = s < 0;
      sm = sneg ? -s : s;
      for (int i = 0; i < 3; i++) begin
        nw = n[i];
        vw = v[i];
        nm = (n[i] < 0) ? -nw : nw;
        num = 4 * nm * sm + dd;
        tm = num / (2 * dd);
        if (tm > (256'sd1 <<< 40)) tm = 256'sd1 <<< 40;
        t = (sneg != (n[i] < 0)) ? -tm : tm;
        r = vw - t;
        if (r > QMAX) r = QMAX;
        if (r < QMIN) r = QMIN;
        res.r[i] = r[23:0];
      end
      return res;
    endfunction

    function void note_request(request_t q);
      pending.push_back(reflect(q));
    endfunction

    task report(string what, logic [23:0] got, logic [23:0] want);
      errors++;
      $display("mismatch on %s: got %0d, expected %0d at %0t", what,
               $signed(got), $signed(want), $realtime);
    endtask

    task check_result(reflection_t got);
      reflection_t want;
      if (pending.size() == 0) begin
        report("unexpected result", got.r[0], 24'd0);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.degen) degenerate_seen++;
      if (got.r[0] !== want.r[0]) report("refl_x", got.r[0], want.r[0]);
      if (got.r[1] !== want.r[1]) report("refl_y", got.r[1], want.r[1]);
      if (got.r[2] !== want.r[2]) report("refl_z", got.r[2], want.r[2]);
      if (got.degen !== want.degen)
        report("degenerate", 24'(got.degen), 24'(want.degen));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic stall_o, valid_o, degenerate_o;
  logic signed [23:0] vec_x_i = '0, vec_y_i = '0, vec_z_i = '0;
  logic signed [23:0] point_a_x_i = '0, point_a_y_i = '0, point_a_z_i = '0;
  logic signed [23:0] point_b_x_i = '0, point_b_y_i = '0, point_b_z_i = '0;
  logic signed [23:0] point_c_x_i = '0, point_c_y_i = '0, point_c_z_i = '0;
  logic signed [23:0] refl_x_o, refl_y_o, refl_z_o;

  reflection_scoreboard sb = new();
  int sent;

  plane_reflection_core u_top (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .vec_x_i, .vec_y_i, .vec_z_i,
    .point_a_x_i, .point_a_y_i, .point_a_z_i,
    .point_b_x_i, .point_b_y_i, .point_b_z_i,
    .point_c_x_i, .point_c_y_i, .point_c_z_i,
    .valid_o, .stall_i,
    .refl_x_o, .refl_y_o, .refl_z_o, .degenerate_o
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  always @(posedge clk_i) begin
    request_t q;
    reflection_t got;
    if (rst_ni) begin
      if (valid_i && !stall_o) begin
        q.v = '{vec_x_i, vec_y_i, vec_z_i};
        q.a = '{point_a_x_i, point_a_y_i, point_a_z_i};
        q.b = '{point_b_x_i, point_b_y_i, point_b_z_i};
        q.c = '{point_c_x_i, point_c_y_i, point_c_z_i};
        sb.note_request(q);
      end
      if (valid_o && !stall_i) begin
        got.r = '{refl_x_o, refl_y_o, refl_z_o};
        got.degen = degenerate_o;
        sb.check_result(got);
      end
    end
  end

  function automatic int gap_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  initial begin
    int len;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      stall_i <= 1'b0;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : gap_length();
      repeat (len) @(negedge clk_i);
      len = gap_length();
      if (len > 0) begin
        stall_i <= 1'b1;
        repeat (len - 1) @(negedge clk_i);
      end
    end
  end

  task automatic send_request(request_t q, bit allow_gap);
    int gap;
    gap = allow_gap ? gap_length() : 0;
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    {vec_x_i, vec_y_i, vec_z_i} <= {q.v[0], q.v[1], q.v[2]};
    {point_a_x_i, point_a_y_i, point_a_z_i} <= {q.a[0], q.a[1], q.a[2]};
    {point_b_x_i, point_b_y_i, point_b_z_i} <= {q.b[0], q.b[1], q.b[2]};
    {point_c_x_i, point_c_y_i, point_c_z_i} <= {q.c[0], q.c[1], q.c[2]};
    valid_i <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (!stall_o) break;
    end
    sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [23:0] pick_extreme();
    case ($urandom_range(0, 5))
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return 24'h000000;
      3: return 24'hffffff;
      4: return 24'h010000;
      default: return 24'h000001;
    endcase
  endfunction

  function automatic logic [23:0] pick_small();
    return 24'($signed($urandom_range(0, 8191)) - 4096);
  endfunction

  function automatic request_t random_request();
    request_t q;
    int kind, k;
    kind = $urandom_range(0, 99);
    for (int i = 0; i < 3; i++) begin
      q.v[i] = 24'($urandom());
      q.a[i] = 24'($urandom());
      q.b[i] = 24'($urandom());
      q.c[i] = 24'($urandom());
    end
    if (kind >= 45 && kind < 70) begin
      for (int i = 0; i < 3; i++) begin
        q.v[i] = pick_small() <<< $urandom_range(0, 11);
        q.a[i] = pick_small();
        q.b[i] = pick_small();
        q.c[i] = pick_small();
      end
    end else if (kind >= 70 && kind < 85) begin
      k = $urandom_range(0, 3);
      for (int i = 0; i < 3; i++) begin
        q.a[i] = pick_small() <<< 8;
        q.b[i] = q.a[i] + pick_small();
        case (k)
          0: q.b[i] = q.a[i];
          1: q.c[i] = q.a[i];
          2: q.c[i] = q.b[i];
          default: q.c[i] = q.a[i] + 24'sd3 * (q.b[i] - q.a[i]);
        endcase
      end
    end else if (kind >= 85 && kind < 95) begin
      for (int i = 0; i < 3; i++) begin
        q.v[i] = pick_extreme();
        q.a[i] = pick_extreme();
        q.b[i] = pick_extreme();
        q.c[i] = pick_extreme();
      end
    end else if (kind >= 95) begin
      k = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) begin
        q.a[i] = '0;
        q.b[i] = '0;
        q.c[i] = '0;
      end
      q.b[(k + 1) % 3] = pick_small() | 24'd1;
      q.c[(k + 2) % 3] = pick_small() | 24'd1;
    end
    return q;
  endfunction

  function automatic request_t make_request(logic [23:0] vx, logic [23:0] vy,
                                            logic [23:0] vz, logic [23:0] ax,
                                            logic [23:0] ay, logic [23:0] az,
                                            logic [23:0] bx, logic [23:0] by,
                                            logic [23:0] bz, logic [23:0] cx,
                                            logic [23:0] cy, logic [23:0] cz);
    request_t q;
    q.v = '{vx, vy, vz};
    q.a = '{ax, ay, az};
    q.b = '{bx, by, bz};
    q.c = '{cx, cy, cz};
    return q;
  endfunction

  initial begin
    request_t directed[$];
    int waited;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    directed.push_back(make_request(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_request(24'h010000, 24'h020000, 24'h030000,
                                    0, 0, 0, 24'h010000, 0, 0, 0, 24'h010000, 0));
    directed.push_back(make_request(24'h7fffff, 24'h7fffff, 24'h7fffff,
                                    0, 0, 0, 24'h010000, 0, 0, 0, 24'h010000, 0));
    directed.push_back(make_request(24'h800000, 24'h800000, 24'h800000,
                                    0, 0, 0, 24'h010000, 0, 0, 0, 24'h010000, 0));
    directed.push_back(make_request(24'h123456, 24'h800000, 24'h7fffff,
                                    24'h050000, 24'h050000, 24'h050000,
                                    24'h050000, 24'h050000, 24'h050000,
                                    24'h050000, 24'h050000, 24'h050000));
    directed.push_back(make_request(24'h7fffff, 24'h800000, 24'h000001,
                                    0, 0, 0, 24'h010000, 24'h010000, 24'h010000,
                                    24'h020000, 24'h020000, 24'h020000));
    directed.push_back(make_request(24'h7fffff, 24'h7fffff, 24'h7fffff,
                                    24'h800000, 24'h800000, 24'h800000,
                                    24'h7fffff, 24'h800000, 24'h800000,
                                    24'h800000, 24'h7fffff, 24'h800000));
    directed.push_back(make_request(24'h800000, 24'h7fffff, 24'h800000,
                                    24'h7fffff, 24'h7fffff, 24'h7fffff,
                                    24'h800000, 24'h7fffff, 24'h800000,
                                    24'h800000, 24'h800000, 24'h7fffff));
    directed.push_back(make_request(24'h7fffff, 24'h7fffff, 24'h7fffff,
                                    0, 0, 0, 24'h000001, 0, 0, 0, 24'h000001, 24'h000001));
    directed.push_back(make_request(24'h000001, 24'hffffff, 24'h000001,
                                    24'h800000, 24'h7fffff, 24'h000000,
                                    24'h7fffff, 24'h800000, 24'h7fffff,
                                    24'h000001, 24'hffffff, 24'h800000));
    directed.push_back(make_request(24'h020000, 24'h010000, 0,
                                    0, 0, 0, 24'h010000, 0, 0, 0, 0, 24'h010000));
    directed.push_back(make_request(24'h000001, 24'h000001, 24'h000001,
                                    0, 0, 0, 24'h000001, 24'h000002, 0,
                                    24'h000002, 24'h000001, 0));
    directed.push_back(make_request(24'hffffff, 24'hffffff, 24'hffffff,
                                    24'hffffff, 24'hffffff, 24'hffffff,
                                    0, 0, 0, 24'hffffff, 24'hffffff, 24'hffffff));
    foreach (directed[i]) send_request(directed[i], 1'b0);

    repeat (NUM_RANDOM) send_request(random_request(), 1'b1);
    valid_i <= 1'b0;

    waited = 0;
    while (sb.pending.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d reflection requests, checked %0d results (%0d degenerate planes).",
             sent, sb.checked, sb.degenerate_seen);
    $display("Both sides idled and stalled at random; %0d mismatches found.", sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(HALF_PERIOD * 2 * 600000);
    $display("Timed out waiting for the core.");
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/prefl_pkg.sv
design/prefl_front.sv
design/prefl_queue.sv
design/prefl_div.sv
design/prefl_back.sv
design/plane_reflection_core.sv
design/prefl_checker.sv
bench/plane_reflection_core_tb.sv
